// ----- src/cits_pkg.sv -----
package cits_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_RANGE = 1'd1;

  localparam logic [31:0] LOOK_AHEAD_RST = 32'd196608;
  localparam logic [30:0] VERT_RANGE_RST = 31'd128000;
  localparam logic [31:0] BEST_TIME_RST  = 32'hFFFF_FFFF;

  // One classified sample, handed from the front end to the back end
  typedef struct packed {
    logic               skip;        // zero rvx, zero rx or separating motion
    logic               from_lower;  // sample X below observer X
    logic               last;        // final sample of a frame
    logic        [32:0] mag_rx;
    logic        [32:0] mag_rvx;
    logic        [32:0] mag_rvz;
    logic               rvz_neg;
    logic signed [32:0] rz;
  } cits_entry_t;

  // Live register values
  typedef struct packed {
    logic [31:0] look_ahead;
    logic [30:0] vert_range;
  } cits_cfg_t;

  // Back end sequencer states
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PRE  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_MUL0 = 9'b000010000,
    S_MUL1 = 9'b000100000,
    S_SEP  = 9'b001000000,
    S_CMP  = 9'b010000000,
    S_FIN  = 9'b100000000
  } cits_state_t;

endpackage

// ----- src/closest_impact_threat_search.sv -----
// Channel   Direction  tdata (low bit up)                          side bits
// in_       slave      sample x,z,vx,vz; observer x,z,vx,vz (8x32) tlast: last_sample
// out_      master     from_lower_x, impact_time, 7 zero bits       tuser: threat_found
// cfg_      write      index 0 look_ahead_time, 1 vertical_range    none
//
// A request that reaches the vertical test goes through load, setup, serial division
// one quotient bit at a time, time check, two multiply halves, sum, compare, finish.
// One that fails the time check goes from there to finish, and one that fails the sign
// or overflow tests from setup to finish. The queue takes new requests until full; the
// output register holds a frame result until out_tready and a frame end waits on it.
// Reset is synchronous, active low, and clears control and running state.
module closest_impact_threat_search
  import cits_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [255:0]         in_tdata,   // sample_x, sample_z, sample_vx, sample_vz,
                                           // observer_x, observer_z, observer_vx,
                                           // observer_vz
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // from_lower_x, impact_time, zero fill
  output logic                 out_tuser,  // threat_found
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cits_cfg_t   cfg_r;
  cits_entry_t push_entry;
  cits_entry_t pop_entry;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic        found;
  logic        lower;
  logic [31:0] itime;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.look_ahead <= LOOK_AHEAD_RST;
      cfg_r.vert_range <= VERT_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOOK_AHEAD: cfg_r.look_ahead <= cfg_data;
        REG_VERT_RANGE: cfg_r.vert_range <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;

  cits_front u_front (
    .sample_data (in_tdata),
    .sample_last (in_tlast),
    .entry       (push_entry)
  );

  cits_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !q_full),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  cits_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_found (found),
    .out_lower (lower),
    .out_time  (itime)
  );

  assign out_tdata = {7'd0, itime, lower};
  assign out_tuser = found;

endmodule

// ----- src/cits_front.sv -----
module cits_front
  import cits_pkg::*;
(
  input  logic [255:0] sample_data,  // sample_x, sample_z, sample_vx, sample_vz,
                                     // observer_x, observer_z, observer_vx, observer_vz
  input  logic         sample_last,
  output cits_entry_t  entry
);

  logic signed [32:0] rx;
  logic signed [32:0] rz;
  logic signed [32:0] rvx;
  logic signed [32:0] rvz;

  // Form relative position and velocity at 33 bits
  always_comb begin
    rx  = {sample_data[31],  sample_data[31:0]}
        - {sample_data[159], sample_data[159:128]};
    rz  = {sample_data[63],  sample_data[63:32]}
        - {sample_data[191], sample_data[191:160]};
    rvx = {sample_data[95],  sample_data[95:64]}
        - {sample_data[223], sample_data[223:192]};
    rvz = {sample_data[127], sample_data[127:96]}
        - {sample_data[255], sample_data[255:224]};
  end

  // Classify: a positive time needs rx nonzero and of opposite sign to rvx
  always_comb begin
    entry.skip       = (rvx == 33'sd0) || (rx == 33'sd0) || (rx[32] == rvx[32]);
    entry.from_lower = rx[32];
    entry.last       = sample_last;
    entry.mag_rx     = rx[32]  ? 33'(-rx)  : 33'(rx);
    entry.mag_rvx    = rvx[32] ? 33'(-rvx) : 33'(rvx);
    entry.mag_rvz    = rvz[32] ? 33'(-rvz) : 33'(rvz);
    entry.rvz_neg    = rvz[32];
    entry.rz         = rz;
  end

endmodule

// ----- src/cits_queue.sv -----
module cits_queue
  import cits_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cits_entry_t push_data,
  input  logic        pop,
  output cits_entry_t pop_data,
  output logic        full,
  output logic        empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cits_entry_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/cits_back.sv -----
module cits_back
  import cits_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cits_cfg_t   cfg,
  input  logic        q_empty,
  input  cits_entry_t q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic        out_lower,
  output logic [31:0] out_time
);

  cits_state_t        state_r,   state_nxt;
  cits_entry_t        ent_r;
  logic        [32:0] rem_r;
  logic        [31:0] shf_r;
  logic        [31:0] quot_r;
  logic        [4:0]  cnt_r;
  logic        [48:0] p0_r;
  logic        [48:0] p1_r;
  logic        [49:0] prod_r;
  logic        [31:0] best_time_r;
  logic               have_r;
  logic               best_lower_r;
  logic               out_valid_r;
  logic               out_found_r;
  logic               out_lower_r;
  logic        [31:0] out_time_r;

  logic               ovf;
  logic        [33:0] trial;
  logic        [33:0] trial_diff;
  logic               time_ok;
  logic signed [51:0] sep;
  logic signed [51:0] vr_s;
  logic               sep_ok;
  logic               out_free;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_lower = out_lower_r;
  assign out_time  = out_time_r;
  assign out_free  = !out_valid_r || out_ready;

  // Quotient of 2^32 or more counts as beyond the look-ahead
  assign ovf = ({16'd0, ent_r.mag_rx} >= {ent_r.mag_rvx, 16'd0});

  // One restoring division step
  assign trial      = {rem_r, shf_r[31]};
  assign trial_diff = trial - {1'b0, ent_r.mag_rvx};

  assign time_ok = (quot_r != 32'd0) && (quot_r <= cfg.look_ahead)
                && (!have_r || (quot_r < best_time_r));

  // Predicted vertical separation against the range
  assign sep    = ent_r.rvz_neg ? (52'(ent_r.rz) - 52'(signed'({2'b00, prod_r})))
                                : (52'(ent_r.rz) + 52'(signed'({2'b00, prod_r})));
  assign vr_s   = 52'(signed'({1'b0, cfg.vert_range}));
  assign sep_ok = (sep <= vr_s) && (sep >= -vr_s);

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_PRE;
      S_PRE:  state_nxt = (ent_r.skip || ovf) ? S_FIN : S_DIV;
      S_DIV:  if (cnt_r == 5'd0) state_nxt = S_CHK;
      S_CHK:  state_nxt = time_ok ? S_MUL0 : S_FIN;
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_SEP;
      S_SEP:  state_nxt = S_CMP;
      S_CMP:  state_nxt = S_FIN;
      S_FIN:  if (!ent_r.last || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: load, divide, multiply in two halves, add
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (!q_empty) ent_r <= q_data;
      S_PRE: begin
        rem_r  <= {16'd0, ent_r.mag_rx[32:16]};
        shf_r  <= {ent_r.mag_rx[15:0], 16'd0};
        quot_r <= '0;
        cnt_r  <= 5'd31;
      end
      S_DIV: begin
        if (!trial_diff[33]) begin
          rem_r  <= trial_diff[32:0];
          quot_r <= {quot_r[30:0], 1'b1};
        end else begin
          rem_r  <= trial[32:0];
          quot_r <= {quot_r[30:0], 1'b0};
        end
        shf_r <= {shf_r[30:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
      end
      S_MUL0: p0_r   <= ent_r.mag_rvz * quot_r[15:0];
      S_MUL1: p1_r   <= ent_r.mag_rvz * quot_r[31:16];
      S_SEP:  prod_r <= {1'b0, p1_r} + {17'd0, p0_r[48:16]};
      default: ;
    endcase
  end

  // Hold the best candidate; clear it when the frame result is loaded for output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_time_r  <= BEST_TIME_RST;
      have_r       <= 1'b0;
      best_lower_r <= 1'b0;
    end else if (state_r == S_CMP && sep_ok) begin
      best_time_r  <= quot_r;
      have_r       <= 1'b1;
      best_lower_r <= ent_r.from_lower;
    end else if (state_r == S_FIN && ent_r.last && out_free) begin
      best_time_r  <= BEST_TIME_RST;
      have_r       <= 1'b0;
      best_lower_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && ent_r.last && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && ent_r.last && out_free) begin
      out_found_r <= have_r;
      out_lower_r <= have_r && best_lower_r;
      out_time_r  <= have_r ? best_time_r : 32'd0;
    end
  end

endmodule

// ----- dv/closest_impact_threat_search_checker.sv -----
`timescale 1ns / 1ps

module closest_impact_threat_search_checker
  import cits_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [255:0]         in_tdata,   // sample_x, sample_z, sample_vx, sample_vz,
                                           // observer_x, observer_z, observer_vx,
                                           // observer_vz
  input  logic                 in_tlast,   // last_sample
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,  // from_lower_x, impact_time, zero fill
  input  logic                 out_tuser,  // threat_found
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   pending,
  output int                   mismatches
);

  typedef struct packed {
    logic        found;
    logic        lower;
    logic [31:0] impact;
  } frame_result_t;

  // Expected frame results, oldest first
  frame_result_t frame_results_q[$];

  // Shadow registers and running search state
  logic [31:0] look_ahead;
  logic [30:0] vert_range;
  logic [31:0] best_time;
  logic        have_threat;
  logic        best_lower;

  int fail_total  = 0;
  int frames_seen = 0;

  assign mismatches = fail_total;

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("[%0t] frame %0d: %s expected 0x%0h got 0x%0h",
             $time, frames_seen, what, want, got);
    fail_total++;
  endtask

  // Judge one sample against the best candidate held for this frame
  task automatic rank_sample(input logic [255:0] req);
    logic signed [31:0] sx, sz, svx, svz, ox, oz, ovx, ovz;
    logic [32:0]        rx, rz, rvx, rvz, mrx, mrvx, mrvz;
    logic [63:0]        quo;
    logic [95:0]        prod;
    logic [66:0]        sep, sep_mag;
    {ovz, ovx, oz, ox, svz, svx, sz, sx} = req;
    rx   = {sx[31], sx} - {ox[31], ox};
    rz   = {sz[31], sz} - {oz[31], oz};
    rvx  = {svx[31], svx} - {ovx[31], ovx};
    rvz  = {svz[31], svz} - {ovz[31], ovz};
    mrx  = rx[32] ? -rx : rx;
    mrvx = rvx[32] ? -rvx : rvx;
    mrvz = rvz[32] ? -rvz : rvz;
    if (rvx == '0) return;
    // a positive time needs a nonzero rx of the opposite sign to rvx
    if (rx == '0 || rx[32] == rvx[32]) return;
    quo = {15'd0, mrx, 16'd0} / {31'd0, mrvx};
    if (quo == '0 || quo > {32'd0, look_ahead}) return;
    if (have_threat && quo[31:0] >= best_time) return;
    // predicted vertical separation at the impact time
    prod    = ({63'd0, mrvz} * {64'd0, quo[31:0]}) >> 16;
    sep     = rvz[32] ? {{34{rz[32]}}, rz} - prod[66:0] : {{34{rz[32]}}, rz} + prod[66:0];
    sep_mag = sep[66] ? -sep : sep;
    if (sep_mag > {36'd0, vert_range}) return;
    have_threat = 1'b1;
    best_time   = quo[31:0];
    best_lower  = (sx < ox);
  endtask

  always @(posedge clk) begin : watch
    frame_result_t want;
    if (!rst_n) begin
      look_ahead  = LOOK_AHEAD_RST;
      vert_range  = VERT_RANGE_RST;
      best_time   = BEST_TIME_RST;
      have_threat = 1'b0;
      best_lower  = 1'b0;
      frame_results_q.delete();
    end else begin
      // Compare a delivered result with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (frame_results_q.size() == 0) begin
          report("unexpected result, impact_time", 32'd0, out_tdata[32:1]);
        end else begin
          want = frame_results_q.pop_front();
          if (out_tuser !== want.found)
            report("threat_found", 32'(want.found), 32'(out_tuser));
          if (out_tdata[0] !== want.lower)
            report("from_lower_x", 32'(want.lower), 32'(out_tdata[0]));
          if (out_tdata[32:1] !== want.impact) report("impact_time", want.impact, out_tdata[32:1]);
          if (out_tdata[39:33] !== 7'd0) report("zero fill", 32'd0, 32'(out_tdata[39:33]));
          frames_seen++;
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_LOOK_AHEAD: look_ahead = cfg_data;
          REG_VERT_RANGE: vert_range = cfg_data[30:0];
          default: ;
        endcase
      end
      // Judge each accepted request; close the frame on the last one
      if (in_tvalid && in_tready) begin
        rank_sample(in_tdata);
        if (in_tlast) begin
          want.found  = have_threat;
          want.lower  = have_threat && best_lower;
          want.impact = have_threat ? best_time : 32'd0;
          frame_results_q.push_back(want);
          best_time   = BEST_TIME_RST;
          have_threat = 1'b0;
          best_lower  = 1'b0;
        end
      end
    end
    pending <= frame_results_q.size();
  end

endmodule

// ----- dv/closest_impact_threat_search_tb.sv -----
`timescale 1ns / 1ps

module closest_impact_threat_search_tb;
  import cits_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 315;

  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;

  // Request layout, sample_x in the lowest bits
  typedef struct packed {
    logic [31:0] observer_vz;
    logic [31:0] observer_vx;
    logic [31:0] observer_z;
    logic [31:0] observer_x;
    logic [31:0] sample_vz;
    logic [31:0] sample_vx;
    logic [31:0] sample_z;
    logic [31:0] sample_x;
  } sample_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [255:0]         in_tdata   = '0;   // sample_x, sample_z, sample_vx, sample_vz,
                                           // observer_x, observer_z, observer_vx,
                                           // observer_vz
  logic                 in_tlast   = 1'b0; // last_sample
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;         // from_lower_x, impact_time, zero fill
  logic                 out_tuser;         // threat_found
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;

  int   pending;
  int   mismatches;
  logic quiet        = 1'b0;
  int   ready_left   = 0;
  int   stall_cycles = 0;

  logic [31:0] la_now;
  logic [30:0] vr_now;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  closest_impact_threat_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  closest_impact_threat_search_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(0, 4))
      0: return MINN;
      1: return MAXP;
      2: return 32'd0;
      3: return 32'd1;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic longint rand_signed(input longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  // Mostly closing traffic aimed around the look-ahead, the rest noise
  function automatic sample_t make_sample(input logic [31:0] la, input logic [30:0] vr);
    sample_t s;
    longint  ox, oz, ovx, ovz, mrx, rx, mrvx, rvx, span, t_goal, rmax, rz, rvz;
    int      kind;
    kind = $urandom_range(0, 99);
    if (kind < 18) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind < 25) begin
      s = {pick_corner(), pick_corner(), pick_corner(), pick_corner(),
           pick_corner(), pick_corner(), pick_corner(), pick_corner()};
    end else begin
      ox  = rand_signed(1 << 24);
      oz  = rand_signed(1 << 24);
      ovx = rand_signed(1 << 29);
      ovz = rand_signed(1 << 24);
      mrx = longint'($urandom_range(1, 1 << 20));
      rx  = ($urandom_range(0, 1) != 0) ? -mrx : mrx;
      if ($urandom_range(0, 49) == 0) rx = 0;
      span = longint'(la) + longint'(la >> 2);
      if (span < 65536) span = 65536;
      t_goal = 1 + longint'({$urandom, $urandom} % span);
      mrvx = (mrx << 16) / t_goal;
      if (mrvx < 1) mrvx = 1;
      if (mrvx > (1 << 30)) mrvx = 1 << 30;
      // closing motion most of the time
      rvx  = ((rx < 0) == ($urandom_range(0, 9) != 0)) ? mrvx : -mrvx;
      rmax = longint'(vr) * 2 + 1;
      if (rmax > (1 << 28)) rmax = 1 << 28;
      rz  = rand_signed(rmax);
      rvz = ($urandom_range(0, 4) == 0) ? 0 : rand_signed(1 << 16);
      s.observer_x  = 32'(ox);
      s.observer_z  = 32'(oz);
      s.observer_vx = 32'(ovx);
      s.observer_vz = 32'(ovz);
      s.sample_x    = 32'(ox + rx);
      s.sample_z    = 32'(oz + rz);
      s.sample_vx   = 32'(ovx + rvx);
      s.sample_vz   = 32'(ovz + rvz);
    end
    return s;
  endfunction

  // Hold off, then present one request until it is taken
  task automatic send_sample(input sample_t s, input logic last);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= s;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_fields(input logic [31:0] sx, sz, svx, svz, ox, oz, ovx, ovz,
                             input logic last);
    sample_t s;
    s.sample_x    = sx;
    s.sample_z    = sz;
    s.sample_vx   = svx;
    s.sample_vz   = svz;
    s.observer_x  = ox;
    s.observer_z  = oz;
    s.observer_vx = ovx;
    s.observer_vz = ovz;
    send_sample(s, last);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending until every expected frame result has come back
  task automatic hold_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Let the back end finish requests that produce no result
  task automatic settle();
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_left <= 0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      out_tready <= ~out_tready;
      ready_left <= out_tready ? pick_gap() : $urandom_range(0, 6);
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("closest_impact_threat_search verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset register values (3 s, 500.0)
    send_fields(25600, 0, 0, 0, 0, 0, 0, 0, 1'b0);           // no relative X motion
    send_fields(0, 0, 2560, 0, 0, 0, 0, 0, 1'b0);            // no X separation
    send_fields(25600, 0, 2560, 0, 0, 0, 0, 0, 1'b0);        // moving apart
    send_fields(1, 0, MINN, 0, 0, 0, 0, 0, 1'b0);            // quotient truncates to zero
    send_fields(25600, 0, -2560, 0, 0, 0, 0, 0, 1'b0);       // impact past look-ahead
    send_fields(MAXP, 0, -1, 0, 0, 0, 0, 0, 1'b0);           // quotient wider than 32 bits
    send_fields(25600, 0, -12800, 0, 0, 0, 0, 0, 1'b0);      // hit at 2 s
    send_fields(-25600, 0, 12800, 0, 0, 0, 0, 0, 1'b0);      // tie with best, dropped
    send_fields(-12800, 0, 12800, 0, 0, 0, 0, 0, 1'b0);      // earlier, from lower X
    send_fields(6400, 128001, -12800, 0, 0, 0, 0, 0, 1'b0);  // vertical just out of range
    send_fields(6400, -128000, -12800, 0, 0, 0, 0, 0, 1'b1); // vertical right at range
    send_fields(25600, 0, 0, 0, 0, 0, 0, 0, 1'b1);           // frame with no threat
    send_fields(768, 0, -256, -25600, 0, 0, 0, 0, 1'b1);     // exactly at look-ahead, sinking
    send_fields(MAXP, MAXP, MAXP, MAXP, MINN, MINN, MINN, MINN, 1'b0);
    send_fields(MINN, MINN, MINN, MINN, MAXP, MAXP, MAXP, MAXP, 1'b0);
    send_fields(MINN, 0, MAXP, 0, MAXP, 0, MINN, 0, 1'b1);   // full-scale hit at 1 s
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    send_fields('1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
    settle();

    // Random phases, registers changed only while the block is idle
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin la_now = LOOK_AHEAD_RST;   vr_now = VERT_RANGE_RST;  end
        1: begin la_now = 32'd0;            vr_now = 31'd0;           end
        2: begin la_now = 32'hFFFF_FFFF;    vr_now = 31'h7FFF_FFFF;   end
        3: begin la_now = 32'd65536;        vr_now = 31'd2560;        end
        4: begin la_now = $urandom;         vr_now = 31'($urandom);   end
        default: begin la_now = 32'd3276800; vr_now = 31'd16777216; end
      endcase
      write_reg(REG_LOOK_AHEAD, la_now);
      write_reg(REG_VERT_RANGE, {1'($urandom_range(0, 1)), vr_now});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 60 == 0) quiet <= ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) hold_for_results();
        send_sample(make_sample(la_now, vr_now), 1'($urandom_range(0, 3) == 0));
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("closest_impact_threat_search verification clean");
    end else begin
      $display("closest_impact_threat_search verification failed");
    end
    $finish;
  end

endmodule
